// ===== hdl/ctig_pkg.sv =====
// Shared types and constants for the cylinder triangle index generator.
// Holds the pipeline stage records and configuration register indexes.
// No dependencies.
package ctig_pkg;

  localparam logic [0:0] REG_POINTS_PER_RING = 1'd0;
  localparam logic [0:0] REG_RING_MODE       = 1'd1;

  localparam logic [1:0] MODE_HOLLOW = 2'd2;
  localparam logic [8:0] MIN_POINTS  = 9'd3;
  localparam logic [8:0] RESET_POINTS = 9'd60;
  localparam logic [1:0] RESET_MODE   = 2'd2;

  typedef struct packed {
    logic [10:0] t;
    logic [8:0]  n;
    logic        hollow;
    logic        in_range;
    logic        last;
  } stage_a_t;

  typedef struct packed {
    logic [9:0]  k;
    logic [1:0]  sec;
    logic [8:0]  n;
    logic [10:0] n3;
    logic        hollow;
    logic        in_range;
    logic        last;
  } stage_b_t;

  typedef struct packed {
    logic [9:0] v0;
    logic [9:0] v1;
    logic [9:0] v2;
    logic       in_range;
    logic       last;
  } result_t;

endpackage

// ===== hdl/ctig_decode.sv =====
// Stage one: ring size saturation, triangle count and range check.
// Depends on ctig_pkg.
module ctig_decode import ctig_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        valid_in,
  input  logic [10:0] t_in,
  input  logic [8:0]  points,
  input  logic [1:0]  mode,
  output logic        valid,
  output stage_a_t    stage
);

  localparam int unsigned NLIM = (MAX_POINTS > 511) ? 511 : MAX_POINTS;
  localparam logic [8:0]  N_MAX = 9'(NLIM);

  logic [8:0]  n;
  logic        hollow;
  logic [11:0] count;
  logic [11:0] tw;
  stage_a_t    stage_next;

  always_comb begin
    if (points < MIN_POINTS) begin
      n = MIN_POINTS;
    end else if (points > N_MAX) begin
      n = N_MAX;
    end else begin
      n = points;
    end
    hollow = (mode == MODE_HOLLOW);
    count = hollow ? {n, 3'b000} : {1'b0, n, 2'b00};
    tw = {1'b0, t_in};
    stage_next.t = t_in;
    stage_next.n = n;
    stage_next.hollow = hollow;
    stage_next.in_range = tw < count;
    stage_next.last = (tw < count) && (tw == count - 12'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== hdl/ctig_section.sv =====
// Stage two: splits the triangle number into list section and offset.
// Depends on ctig_pkg.
module ctig_section import ctig_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     valid_in,
  input  stage_a_t stage_in,
  output logic     valid,
  output stage_b_t stage
);

  logic [11:0] tw, n1, n2, n4, n6, base;
  logic [1:0]  sec;
  stage_b_t    stage_next;

  always_comb begin
    tw = {1'b0, stage_in.t};
    n1 = {3'b000, stage_in.n};
    n2 = {2'b00, stage_in.n, 1'b0};
    n4 = {1'b0, stage_in.n, 2'b00};
    n6 = n4 + n2;
    if (stage_in.hollow) begin
      if (tw < n2) begin
        sec = 2'd0;
        base = 12'd0;
      end else if (tw < n4) begin
        sec = 2'd1;
        base = n2;
      end else if (tw < n6) begin
        sec = 2'd2;
        base = n4;
      end else begin
        sec = 2'd3;
        base = n6;
      end
    end else begin
      if (tw < n1) begin
        sec = 2'd0;
        base = 12'd0;
      end else if (tw < n2) begin
        sec = 2'd1;
        base = n1;
      end else begin
        sec = 2'd2;
        base = n2;
      end
    end
    stage_next.k = 10'(tw - base);
    stage_next.sec = sec;
    stage_next.n = stage_in.n;
    stage_next.n3 = 11'(n2 + n1);
    stage_next.hollow = stage_in.hollow;
    stage_next.in_range = stage_in.in_range;
    stage_next.last = stage_in.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== hdl/ctig_vertex.sv =====
// Stage three: forms the three vertex indices and holds the output register.
// Depends on ctig_pkg.
module ctig_vertex import ctig_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     valid_in,
  input  stage_b_t stage_in,
  output logic     valid,
  output result_t  result
);

  logic [11:0] nw, n2, n3, kw, mw, nxt, prev;
  logic [11:0] a, b, c;
  logic        odd;
  result_t     result_next;

  always_comb begin
    nw = {3'b000, stage_in.n};
    n2 = {2'b00, stage_in.n, 1'b0};
    n3 = {1'b0, stage_in.n3};
    kw = {2'b00, stage_in.k};
    mw = {3'b000, stage_in.k[9:1]};
    odd = stage_in.k[0];
    nxt = (mw + 12'd1 == nw) ? 12'd0 : mw + 12'd1;
    prev = (mw == 12'd0) ? nw - 12'd1 : mw - 12'd1;
    a = 12'd0;
    b = 12'd0;
    c = 12'd0;
    if (stage_in.hollow) begin
      case (stage_in.sec)
        2'd0: begin
          if (!odd) begin
            a = mw; b = nxt; c = mw + nw;
          end else begin
            a = prev + nw; b = mw; c = mw + nw;
          end
        end
        2'd1: begin
          if (!odd) begin
            a = n2 + mw; b = nxt + n2; c = n3 + mw;
          end else begin
            a = prev + n3; b = n2 + mw; c = n3 + mw;
          end
        end
        2'd2: begin
          if (!odd) begin
            a = mw; b = nxt; c = mw + n2;
          end else begin
            a = nxt; b = nxt + n2; c = mw + n2;
          end
        end
        default: begin
          if (!odd) begin
            a = nw + mw; b = nxt + nw; c = n3 + mw;
          end else begin
            a = nxt + nw; b = nxt + n3; c = n3 + mw;
          end
        end
      endcase
    end else begin
      case (stage_in.sec)
        2'd0: begin
          a = 12'd0;
          if (kw < nw - 12'd1) begin
            b = kw + 12'd1; c = kw + 12'd2;
          end else begin
            b = nw; c = 12'd1;
          end
        end
        2'd1: begin
          a = nw + 12'd1;
          if (kw < nw - 12'd1) begin
            b = nw + 12'd2 + kw; c = nw + 12'd3 + kw;
          end else begin
            b = n2 + 12'd1; c = nw + 12'd2;
          end
        end
        default: begin
          if (mw < nw - 12'd1) begin
            if (!odd) begin
              a = mw + 12'd1; b = mw + 12'd2; c = nw + 12'd2 + mw;
            end else begin
              a = mw + 12'd2; b = nw + 12'd2 + mw; c = nw + 12'd3 + mw;
            end
          end else begin
            if (!odd) begin
              a = nw; b = 12'd1; c = n2 + 12'd1;
            end else begin
              a = 12'd1; b = n2 + 12'd1; c = nw + 12'd2;
            end
          end
        end
      endcase
    end
    if (!stage_in.in_range) begin
      a = 12'd0;
      b = 12'd0;
      c = 12'd0;
    end
    result_next.v0 = a[9:0];
    result_next.v1 = b[9:0];
    result_next.v2 = c[9:0];
    result_next.in_range = stage_in.in_range;
    result_next.last = stage_in.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

// ===== hdl/cylinder_triangle_index_generator.sv =====
// Cylinder triangle index generator, top level.
// Uses ctig_pkg, ctig_decode, ctig_section and ctig_vertex.
//
// Usage:
//   Input channel (in_valid/in_ready, triangle_number) takes one triangle
//   number per transfer. Output channel (out_valid/out_ready) gives the three
//   vertex indices, in_range and last_triangle of that triangle, in order.
//   Configuration: cfg_write with cfg_index 0 sets points_per_ring (saturated
//   to 3..MAX_POINTS, at most 511, on use), index 1 sets ring_mode (2 = hollow
//   tube, other codes = solid cylinder). Write only while the pipeline is empty.
//   Pipeline: 3 register stages (decode, section and vertex, the last being the
//   output register), each registering the result of the one before.
//   Throughput: one triangle per cycle while out_ready holds; each stage is a single register.
//   Stall: a stage holds while the stage after it is full and held; empty
//   stages keep filling, so in_ready drops only once all three are full.
//   Reset: pipeline emptied, points_per_ring = 60, ring_mode = 2.
module cylinder_triangle_index_generator import ctig_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] triangle_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  vertex_first,
  output logic [9:0]  vertex_second,
  output logic [9:0]  vertex_third,
  output logic        in_range,
  output logic        last_triangle,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [8:0] points_per_ring;
  logic [1:0] ring_mode;
  logic       en_a, en_b, en_c;
  logic       valid_a, valid_b, valid_c;
  stage_a_t   stage_a;
  stage_b_t   stage_b;
  result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_per_ring <= RESET_POINTS;
      ring_mode <= RESET_MODE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POINTS_PER_RING: points_per_ring <= cfg_data;
        REG_RING_MODE:       ring_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign en_c = !valid_c || out_ready;
  assign en_b = !valid_b || en_c;
  assign en_a = !valid_a || en_b;
  assign in_ready = en_a;

  ctig_decode #(
    .MAX_POINTS(MAX_POINTS)
  ) u_decode (
    .clk(clk),
    .rst(rst),
    .en(en_a),
    .valid_in(in_valid),
    .t_in(triangle_number),
    .points(points_per_ring),
    .mode(ring_mode),
    .valid(valid_a),
    .stage(stage_a)
  );

  ctig_section u_section (
    .clk(clk),
    .rst(rst),
    .en(en_b),
    .valid_in(valid_a),
    .stage_in(stage_a),
    .valid(valid_b),
    .stage(stage_b)
  );

  ctig_vertex u_vertex (
    .clk(clk),
    .rst(rst),
    .en(en_c),
    .valid_in(valid_b),
    .stage_in(stage_b),
    .valid(valid_c),
    .result(result)
  );

  assign out_valid = valid_c;
  assign vertex_first = result.v0;
  assign vertex_second = result.v1;
  assign vertex_third = result.v2;
  assign in_range = result.in_range;
  assign last_triangle = result.last;

`ifndef NO_ASSERTIONS
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_range) |->
      (vertex_first == 10'd0 && vertex_second == 10'd0 && vertex_third == 10'd0))
    else $error("out-of-range triangle with nonzero indices");

  a_last_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_triangle) |-> in_range)
    else $error("last_triangle set outside the list");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (valid_a && valid_b && valid_c && !out_ready))
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for cylinder_triangle_index_generator: directed table, then random triangle
// numbers under several ring sizes and modes, scored against an in-bench predictor.
// Depends on ctig_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import ctig_pkg::*;

  localparam logic [1:0] MODE_SOLID       = 2'd0;
  localparam logic [1:0] MODE_SOLID_ALT   = 2'd1;
  localparam logic [1:0] MODE_SOLID_SPARE = 2'd3;
  localparam int unsigned RING_MAX = 256;
  localparam int DRAIN_CYCLES = 8;
  localparam int ROWS = 24;

  typedef struct packed {
    logic [9:0] v_first;
    logic [9:0] v_second;
    logic [9:0] v_third;
    logic       in_rng;
    logic       last_tri;
  } tri_result_t;

  typedef struct packed {
    logic [8:0]  ring;
    logic [1:0]  mode;
    logic [10:0] tri_num;
    logic        typed;
    tri_result_t result;
  } tri_row_t;

  localparam tri_row_t DIRECTED_ROWS [ROWS] = '{
    '{9'd60,  MODE_HOLLOW,      11'd0,    1'b1, '{10'd0,   10'd1,   10'd60,   1'b1, 1'b0}},
    '{9'd60,  MODE_HOLLOW,      11'd1,    1'b1, '{10'd119, 10'd0,   10'd60,   1'b1, 1'b0}},
    '{9'd60,  MODE_HOLLOW,      11'd130,  1'b0, '0},
    '{9'd60,  MODE_HOLLOW,      11'd250,  1'b0, '0},
    '{9'd60,  MODE_HOLLOW,      11'd370,  1'b0, '0},
    '{9'd60,  MODE_HOLLOW,      11'd479,  1'b1, '{10'd60,  10'd180, 10'd239,  1'b1, 1'b1}},
    '{9'd60,  MODE_HOLLOW,      11'd480,  1'b1, '0},
    '{9'd60,  MODE_HOLLOW,      11'd2047, 1'b1, '0},
    '{9'd3,   MODE_SOLID,       11'd0,    1'b1, '{10'd0,   10'd1,   10'd2,    1'b1, 1'b0}},
    '{9'd3,   MODE_SOLID,       11'd2,    1'b1, '{10'd0,   10'd3,   10'd1,    1'b1, 1'b0}},
    '{9'd3,   MODE_SOLID,       11'd5,    1'b1, '{10'd4,   10'd7,   10'd5,    1'b1, 1'b0}},
    '{9'd3,   MODE_SOLID,       11'd6,    1'b0, '0},
    '{9'd3,   MODE_SOLID,       11'd11,   1'b1, '{10'd1,   10'd7,   10'd5,    1'b1, 1'b1}},
    '{9'd3,   MODE_SOLID,       11'd12,   1'b1, '0},
    '{9'd0,   MODE_SOLID_ALT,   11'd11,   1'b1, '{10'd1,   10'd7,   10'd5,    1'b1, 1'b1}},
    '{9'd511, MODE_SOLID_SPARE, 11'd1023, 1'b1, '{10'd1,   10'd513, 10'd258,  1'b1, 1'b1}},
    '{9'd511, MODE_SOLID_SPARE, 11'd1024, 1'b1, '0},
    '{9'd256, MODE_HOLLOW,      11'd0,    1'b1, '{10'd0,   10'd1,   10'd256,  1'b1, 1'b0}},
    '{9'd256, MODE_HOLLOW,      11'd1,    1'b1, '{10'd511, 10'd0,   10'd256,  1'b1, 1'b0}},
    '{9'd256, MODE_HOLLOW,      11'd2047, 1'b1, '{10'd256, 10'd768, 10'd1023, 1'b1, 1'b1}},
    '{9'd2,   MODE_HOLLOW,      11'd23,   1'b0, '0},
    '{9'd2,   MODE_HOLLOW,      11'd24,   1'b1, '0},
    '{9'd257, MODE_HOLLOW,      11'd1024, 1'b0, '0},
    '{9'd1,   MODE_SOLID_ALT,   11'd5,    1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [10:0] triangle_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  vertex_first;
  logic [9:0]  vertex_second;
  logic [9:0]  vertex_third;
  logic        in_range;
  logic        last_triangle;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = REG_POINTS_PER_RING;
  logic [8:0]  cfg_data = '0;

  logic [8:0]  cfg_ring = RESET_POINTS;
  logic [1:0]  cfg_mode = RESET_MODE;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  logic        next_typed = 1'b0;
  tri_result_t next_result = '0;
  tri_result_t tri_expected [$];

  cylinder_triangle_index_generator uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .triangle_number(triangle_number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .vertex_first(vertex_first),
    .vertex_second(vertex_second),
    .vertex_third(vertex_third),
    .in_range(in_range),
    .last_triangle(last_triangle),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned ring_size(logic [8:0] ring);
    int unsigned n;
    n = ring;
    if (n < 3) n = 3;
    if (n > RING_MAX) n = RING_MAX;
    return n;
  endfunction

  function automatic int unsigned list_length(logic [8:0] ring, logic [1:0] mode);
    return (mode == MODE_HOLLOW ? 8 : 4) * ring_size(ring);
  endfunction

  function automatic tri_result_t predict_triangle(logic [8:0] ring, logic [1:0] mode,
                                                   logic [10:0] tri_num);
    int unsigned n, t, count, k, j, i, m, nxt, sec, a, b, c;
    logic odd;
    tri_result_t r;
    n = ring_size(ring);
    t = tri_num;
    count = list_length(ring, mode);
    r = '0;
    if (t >= count) return r;
    a = 0;
    b = 0;
    c = 0;
    if (mode != MODE_HOLLOW) begin
      if (t < n) begin
        if (t < n - 1) begin
          a = 0; b = t + 1; c = t + 2;
        end else begin
          a = 0; b = n; c = 1;
        end
      end else if (t < 2 * n) begin
        k = t - n;
        if (k < n - 1) begin
          a = n + 1; b = n + 2 + k; c = n + 3 + k;
        end else begin
          a = n + 1; b = 2 * n + 1; c = n + 2;
        end
      end else begin
        k = t - 2 * n;
        j = k >> 1;
        odd = k[0];
        i = j + 1;
        if (j < n - 1) begin
          if (!odd) begin
            a = i; b = i + 1; c = n + 1 + i;
          end else begin
            a = i + 1; b = n + 1 + i; c = n + 2 + i;
          end
        end else if (!odd) begin
          a = n; b = 1; c = 2 * n + 1;
        end else begin
          a = 1; b = 2 * n + 1; c = n + 2;
        end
      end
    end else begin
      sec = t / (2 * n);
      k = t - sec * 2 * n;
      m = k >> 1;
      odd = k[0];
      nxt = (m + 1) % n;
      if (sec == 0) begin
        if (!odd) begin
          a = m; b = nxt; c = m + n;
        end else begin
          a = (m == 0) ? 2 * n - 1 : m + n - 1; b = m; c = m + n;
        end
      end else if (sec == 1) begin
        if (!odd) begin
          a = 2 * n + m; b = nxt + 2 * n; c = 3 * n + m;
        end else begin
          a = (m == 0) ? 4 * n - 1 : 3 * n + m - 1; b = 2 * n + m; c = 3 * n + m;
        end
      end else if (sec == 2) begin
        if (!odd) begin
          a = m; b = nxt; c = m + 2 * n;
        end else begin
          a = nxt; b = nxt + 2 * n; c = m + 2 * n;
        end
      end else begin
        if (!odd) begin
          a = n + m; b = nxt + n; c = 3 * n + m;
        end else begin
          a = nxt + n; b = nxt + 3 * n; c = 3 * n + m;
        end
      end
    end
    r.v_first  = a[9:0];
    r.v_second = b[9:0];
    r.v_third  = c[9:0];
    r.in_rng   = 1'b1;
    r.last_tri = (t == count - 1);
    return r;
  endfunction

  function automatic logic [10:0] pick_triangle();
    int unsigned count, sel, t;
    count = list_length(cfg_ring, cfg_mode);
    sel = $urandom_range(99);
    if (sel < 75) t = $urandom_range(count - 1);
    else if (sel < 85) t = count - 2 + $urandom_range(3);
    else t = $urandom_range(2047);
    if (t > 2047) t = 2047;
    return t[10:0];
  endfunction

  task automatic send_triangle(logic [10:0] tri_num, logic typed, tri_result_t result);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    next_typed = typed;
    next_result = result;
    in_valid <= 1'b1;
    triangle_number <= tri_num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tri_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [8:0] ring, logic [1:0] mode);
    drain_pipeline();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_POINTS_PER_RING;
    cfg_data <= ring;
    @(negedge clk);
    cfg_index <= REG_RING_MODE;
    cfg_data <= {7'($urandom), mode};
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_ring = ring;
    cfg_mode = mode;
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    tri_result_t want;
    tri_result_t accepted;
    if (!rst) begin
      if (in_valid && in_ready) begin
        accepted = next_typed ? next_result
                              : predict_triangle(cfg_ring, cfg_mode, triangle_number);
        tri_expected = {tri_expected, accepted};
      end
      if (out_valid && out_ready) begin
        if (tri_expected.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = tri_expected.pop_front();
          if (vertex_first !== want.v_first) begin
            $error("vertex_first expected %0d got %0d", want.v_first, vertex_first);
            mismatches++;
          end
          if (vertex_second !== want.v_second) begin
            $error("vertex_second expected %0d got %0d", want.v_second, vertex_second);
            mismatches++;
          end
          if (vertex_third !== want.v_third) begin
            $error("vertex_third expected %0d got %0d", want.v_third, vertex_third);
            mismatches++;
          end
          if (in_range !== want.in_rng) begin
            $error("in_range expected %0d got %0d", want.in_rng, in_range);
            mismatches++;
          end
          if (last_triangle !== want.last_tri) begin
            $error("last_triangle expected %0d got %0d", want.last_tri, last_triangle);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    tri_row_t row;
    logic [8:0] ring;
    logic [1:0] mode;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.ring != cfg_ring || row.mode != cfg_mode) set_config(row.ring, row.mode);
      send_triangle(row.tri_num, row.typed, row.result);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 22 : 0;
      for (int c = 0; c < 6; c++) begin
        if ($urandom_range(99) < 25) begin
          case ($urandom_range(5))
            0: ring = 9'd0;
            1: ring = 9'd2;
            2: ring = 9'd3;
            3: ring = 9'd256;
            4: ring = 9'd257;
            default: ring = 9'd511;
          endcase
        end else begin
          ring = 9'($urandom_range(3, RING_MAX));
        end
        mode = $urandom_range(1) ? MODE_HOLLOW : 2'($urandom_range(3));
        set_config(ring, mode);
        for (int i = 0; i < 90; i++) send_triangle(pick_triangle(), 1'b0, '0);
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
